@@ src/mgi_pkg.sv @@
// Shared types and constants for the multilinear grid interpolator.
// No dependencies; every other file imports this package.
`default_nettype none

package mgi_pkg;

    localparam int MAX_DIMS   = 3;
    localparam int MAX_POINTS = 16;
    localparam int VALUE_W    = 32;
    localparam int PT_W       = 4;                          // index within one dimension
    localparam int NPT_W      = 5;                          // point count register
    localparam int DIM_W      = 2;
    localparam int BP_DEPTH   = MAX_DIMS * MAX_POINTS;
    localparam int BP_AW      = DIM_W + PT_W;
    localparam int TB_DEPTH   = MAX_POINTS * MAX_POINTS * MAX_POINTS;
    localparam int TB_AW      = 3 * PT_W;
    localparam int ACC_W      = 4 * VALUE_W;                // wide product, four limbs
    localparam int VOL_W      = 3 * VALUE_W;                // cell volume
    localparam int SUM_W      = ACC_W + 4;                  // signed sum of eight corners
    localparam int QUO_W      = SUM_W - 1;                  // magnitude of that sum
    localparam int CNT_W      = 8;                          // divider step counter
    localparam int FQ_DEPTH   = 4;
    localparam int FQ_AW      = 2;
    localparam int FQ_CW      = 3;

    // command codes
    localparam logic [1:0] CMD_BP    = 2'd0;
    localparam logic [1:0] CMD_TB    = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PTS0 = 2'd0;
    localparam logic [1:0] CFG_PTS1 = 2'd1;
    localparam logic [1:0] CFG_PTS2 = 2'd2;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [1:0]                dim_select;
        logic [PT_W-1:0]           point_index;
        logic [TB_AW-1:0]          table_address;
        logic signed [VALUE_W-1:0] load_value;
        logic signed [VALUE_W-1:0] coord0;
        logic signed [VALUE_W-1:0] coord1;
        logic signed [VALUE_W-1:0] coord2;
    } t_in_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] interpolated;
        logic                      status;
    } t_out_rsp;

    typedef enum logic [1:0] {
        JOB_BP,
        JOB_TB,
        JOB_QUERY
    } t_job_kind;

    typedef struct packed {
        t_job_kind                 kind;
        logic [TB_AW-1:0]          addr;
        logic signed [VALUE_W-1:0] data;
        logic signed [VALUE_W-1:0] c0;
        logic signed [VALUE_W-1:0] c1;
        logic signed [VALUE_W-1:0] c2;
    } t_job;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIM,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DIM_END,
        S_VOL,
        S_VOL2,
        S_VOL3,
        S_MUL,
        S_CORNER,
        S_CM1,
        S_CM2,
        S_CM3,
        S_DIV_INIT,
        S_DIV,
        S_ROUND,
        S_SAT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

@@ src/mgi_front.sv @@
// Front end: accepts requests, drops the ones that do nothing, forms jobs.
// Depends on mgi_pkg.
`default_nettype none

module mgi_front (
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  mgi_pkg::t_in_req i_in_req,
    input  wire              i_full,
    output logic             o_push,
    output mgi_pkg::t_job    o_job
);
    import mgi_pkg::*;

    logic keep;

    always_comb begin
        keep        = 1'b0;
        o_job.kind  = JOB_QUERY;
        o_job.addr  = i_in_req.table_address;
        o_job.data  = i_in_req.load_value;
        o_job.c0    = i_in_req.coord0;
        o_job.c1    = i_in_req.coord1;
        o_job.c2    = i_in_req.coord2;
        case (i_in_req.cmd)
            CMD_BP: begin
                keep       = (32'(i_in_req.dim_select) < MAX_DIMS);
                o_job.kind = JOB_BP;
                o_job.addr = TB_AW'({i_in_req.dim_select, i_in_req.point_index});
            end
            CMD_TB: begin
                keep       = 1'b1;
                o_job.kind = JOB_TB;
            end
            CMD_QUERY: begin
                keep       = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full && keep;

endmodule

`default_nettype wire

@@ src/mgi_fifo.sv @@
// Short job queue between front end and execution back end.
// Depends on mgi_pkg.
`default_nettype none

module mgi_fifo (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  mgi_pkg::t_job i_job,
    input  wire           i_pop,
    output mgi_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import mgi_pkg::*;

    t_job             r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wr;
    logic [FQ_AW-1:0] r_rd;
    logic [FQ_CW-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == FQ_CW'(FQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + FQ_CW'(do_push) - FQ_CW'(do_pop);
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FQ_CW'(FQ_DEPTH))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FQ_AW'(r_wr - r_rd) == r_cnt[FQ_AW-1:0])
        else $error("queue pointers disagree with count");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |=> o_full)
        else $error("full queue drained without pop");
`endif

endmodule

`default_nettype wire

@@ src/mgi_back.sv @@
// Back end: point-count registers, base point and table memories, query sequencer
// with a limb-serial multiplier and a restoring divider. Depends on mgi_pkg.
`default_nettype none

module mgi_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_valid,
    input  wire  [1:0]        i_cfg_index,
    input  wire  [4:0]        i_cfg_data,
    input  mgi_pkg::t_job     i_job,
    input  wire               i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output mgi_pkg::t_out_rsp o_out_rsp
);
    import mgi_pkg::*;

    localparam logic [SUM_W-1:0] LIM_POS = SUM_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
    localparam logic [SUM_W-1:0] LIM_NEG = SUM_W'(64'd1 << (VALUE_W - 1));

    // memories
    logic signed [VALUE_W-1:0] bp_mem [BP_DEPTH];
    logic signed [VALUE_W-1:0] tb_mem [TB_DEPTH];
    logic signed [VALUE_W-1:0] r_bp_rdata;
    logic signed [VALUE_W-1:0] r_tb_rdata;

    t_state r_state, n_state, r_ret;

    logic [NPT_W-1:0]          r_npts [MAX_DIMS];
    logic signed [VALUE_W-1:0] r_x    [MAX_DIMS];
    logic [PT_W-1:0]           r_idx  [MAX_DIMS];
    logic [VALUE_W-1:0]        r_w0   [MAX_DIMS];
    logic [VALUE_W-1:0]        r_w1   [MAX_DIMS];
    logic [VALUE_W-1:0]        r_gap  [MAX_DIMS];

    logic [DIM_W-1:0]          r_d;
    logic [PT_W-1:0]           r_j;
    logic [PT_W-1:0]           r_i;
    logic signed [VALUE_W-1:0] r_prev, r_lo, r_hi;
    logic                      r_err;

    logic [ACC_W-1:0]          r_acc;
    logic [VALUE_W-1:0]        r_m;
    logic [VALUE_W-1:0]        r_carry;
    logic [1:0]                r_limb;
    logic [VOL_W-1:0]          r_vol;
    logic [2:0]                r_c;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      r_neg;
    logic [QUO_W-1:0]          r_num;
    logic [VOL_W-1:0]          r_rem;
    logic [CNT_W-1:0]          r_cnt;
    logic [SUM_W-1:0]          r_mag;
    t_out_rsp                  r_res, r_out;
    logic                      r_out_valid;

    // combinational
    logic                      bp_re, tb_re, bp_we, tb_we, out_load;
    logic [BP_AW-1:0]          bp_raddr;
    logic [TB_AW-1:0]          tb_raddr;
    logic [VALUE_W-1:0]        wsel [MAX_DIMS];
    logic                      corner_zero;
    logic [NPT_W-1:0]          npts_d;
    logic                      last_pt;
    logic [2*VALUE_W-1:0]      mul_t;
    logic [VOL_W:0]            rem_sh;
    logic                      div_ge;
    logic signed [VALUE_W-1:0] xc;
    logic [VALUE_W-1:0]        v_abs;

    function automatic logic [NPT_W-1:0] eff_points(input logic [NPT_W-1:0] v);
        if (v == '0) return NPT_W'(1);
        if (v > NPT_W'(MAX_POINTS)) return NPT_W'(MAX_POINTS);
        return v;
    endfunction

    always_comb begin
        corner_zero = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            wsel[d] = r_c[d] ? r_w1[d] : r_w0[d];
            if (wsel[d] == '0) corner_zero = 1'b1;
        end
    end

    assign npts_d  = r_npts[r_d];
    assign last_pt = ({1'b0, r_j} == npts_d - NPT_W'(1));
    assign mul_t   = (2*VALUE_W)'(r_acc[VALUE_W-1:0]) * (2*VALUE_W)'(r_m)
                   + (2*VALUE_W)'(r_carry);
    assign rem_sh  = {r_rem, r_num[QUO_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_vol});
    assign v_abs   = r_tb_rdata[VALUE_W-1] ? VALUE_W'(-r_tb_rdata) : VALUE_W'(r_tb_rdata);

    always_comb begin
        if (r_x[r_d] < r_lo)       xc = r_lo;
        else if (r_x[r_d] >= r_hi) xc = r_hi;
        else                       xc = r_x[r_d];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (!i_empty && i_job.kind == JOB_QUERY) n_state = S_DIM;
            S_DIM:     n_state = (npts_d < NPT_W'(2)) ? S_DIM_END : S_SCAN_RD;
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: n_state = last_pt ? S_DIM_END : S_SCAN_RD;
            S_DIM_END: begin
                if (r_d != DIM_W'(MAX_DIMS - 1)) n_state = S_DIM;
                else if (r_err)                  n_state = S_OUT;
                else                             n_state = S_VOL;
            end
            S_VOL:     n_state = S_MUL;
            S_VOL2:    n_state = S_MUL;
            S_VOL3:    n_state = S_CORNER;
            S_MUL:     if (r_limb == 2'd3) n_state = r_ret;
            S_CORNER: begin
                if (!corner_zero)       n_state = S_MUL;
                else if (r_c == 3'd7)   n_state = S_DIV_INIT;
            end
            S_CM1:     n_state = S_MUL;
            S_CM2:     n_state = S_MUL;
            S_CM3:     n_state = (r_c == 3'd7) ? S_DIV_INIT : S_CORNER;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV:     if (r_cnt == CNT_W'(QUO_W - 1)) n_state = S_ROUND;
            S_ROUND:   n_state = S_SAT;
            S_SAT:     n_state = S_OUT;
            S_OUT:     if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop    = 1'b0;
        bp_we    = 1'b0;
        tb_we    = 1'b0;
        bp_re    = 1'b0;
        tb_re    = 1'b0;
        out_load = 1'b0;
        bp_raddr = {r_d, r_j};
        tb_raddr = {PT_W'(r_idx[2] + PT_W'(r_c[2])),
                    PT_W'(r_idx[1] + PT_W'(r_c[1])),
                    PT_W'(r_idx[0] + PT_W'(r_c[0]))};
        case (r_state)
            S_IDLE: begin
                o_pop = !i_empty;
                bp_we = !i_empty && i_job.kind == JOB_BP;
                tb_we = !i_empty && i_job.kind == JOB_TB;
            end
            S_SCAN_RD: bp_re = 1'b1;
            S_CORNER:  tb_re = !corner_zero;
            S_OUT:     out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (bp_we) bp_mem[i_job.addr[BP_AW-1:0]] <= i_job.data;
        if (bp_re) r_bp_rdata <= bp_mem[bp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tb_we) tb_mem[i_job.addr] <= i_job.data;
        if (tb_re) r_tb_rdata <= tb_mem[tb_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int d = 0; d < MAX_DIMS; d++) r_npts[d] <= NPT_W'(1);
        end else begin
            r_state <= n_state;
            if (out_load)          r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PTS0: r_npts[0] <= eff_points(i_cfg_data);
                    CFG_PTS1: r_npts[1] <= eff_points(i_cfg_data);
                    CFG_PTS2: r_npts[2] <= eff_points(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= r_res;
        case (r_state)
            S_IDLE: begin
                r_d   <= '0;
                r_err <= 1'b0;
                r_x[0] <= i_job.c0;
                r_x[1] <= i_job.c1;
                r_x[2] <= i_job.c2;
            end
            S_DIM: r_j <= '0;
            S_SCAN_EV: begin
                if (r_j != '0 && r_prev >= r_bp_rdata) r_err <= 1'b1;
                if (r_j != '0 && r_i == PT_W'(r_j - 1'b1)) r_hi <= r_bp_rdata;
                if (r_j == '0 ||
                    ({1'b0, r_j} <= npts_d - NPT_W'(2) && r_x[r_d] >= r_bp_rdata)) begin
                    r_i  <= r_j;
                    r_lo <= r_bp_rdata;
                end
                r_prev <= r_bp_rdata;
                r_j    <= r_j + 1'b1;
            end
            S_DIM_END: begin
                if (npts_d < NPT_W'(2)) begin
                    r_idx[r_d] <= '0;
                    r_w0[r_d]  <= VALUE_W'(1);
                    r_w1[r_d]  <= '0;
                    r_gap[r_d] <= VALUE_W'(1);
                end else begin
                    r_idx[r_d] <= r_i;
                    r_w0[r_d]  <= VALUE_W'(r_hi - xc);
                    r_w1[r_d]  <= VALUE_W'(xc - r_lo);
                    r_gap[r_d] <= VALUE_W'(r_hi - r_lo);
                end
                r_d <= r_d + 1'b1;
                r_res.interpolated <= '0;
                r_res.status       <= 1'b1;
            end
            S_VOL: begin
                r_acc   <= ACC_W'(r_gap[0]);
                r_m     <= r_gap[1];
                r_carry <= '0;
                r_limb  <= '0;
                r_ret   <= S_VOL2;
            end
            S_VOL2: begin
                r_m     <= r_gap[2];
                r_carry <= '0;
                r_limb  <= '0;
                r_ret   <= S_VOL3;
            end
            S_VOL3: begin
                r_vol <= r_acc[VOL_W-1:0];
                r_c   <= '0;
                r_sum <= '0;
            end
            S_MUL: begin
                r_acc   <= {mul_t[VALUE_W-1:0], r_acc[ACC_W-1:VALUE_W]};
                r_carry <= mul_t[2*VALUE_W-1:VALUE_W];
                r_limb  <= r_limb + 1'b1;
            end
            S_CORNER: begin
                if (corner_zero) begin
                    r_c <= r_c + 1'b1;
                end else begin
                    r_acc   <= ACC_W'(wsel[0]);
                    r_m     <= wsel[1];
                    r_carry <= '0;
                    r_limb  <= '0;
                    r_ret   <= S_CM1;
                end
            end
            S_CM1: begin
                r_m     <= wsel[2];
                r_carry <= '0;
                r_limb  <= '0;
                r_ret   <= S_CM2;
            end
            S_CM2: begin
                r_m     <= v_abs;
                r_neg   <= r_tb_rdata[VALUE_W-1];
                r_carry <= '0;
                r_limb  <= '0;
                r_ret   <= S_CM3;
            end
            S_CM3: begin
                if (r_neg) r_sum <= r_sum - $signed({4'b0, r_acc});
                else       r_sum <= r_sum + $signed({4'b0, r_acc});
                r_c <= r_c + 1'b1;
            end
            S_DIV_INIT: begin
                r_neg <= r_sum[SUM_W-1];
                r_num <= r_sum[SUM_W-1] ? QUO_W'(-r_sum) : QUO_W'(r_sum);
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? VOL_W'(rem_sh - {1'b0, r_vol}) : rem_sh[VOL_W-1:0];
                r_num <= {r_num[QUO_W-2:0], div_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_ROUND: begin
                // round half away from zero on the magnitude
                r_mag <= SUM_W'(r_num) + SUM_W'({r_rem, 1'b0} >= {1'b0, r_vol});
            end
            S_SAT: begin
                r_res.status <= 1'b0;
                if (r_neg) begin
                    r_res.interpolated <= (r_mag > LIM_NEG) ? LIM_NEG[VALUE_W-1:0]
                                                            : -r_mag[VALUE_W-1:0];
                end else begin
                    r_res.interpolated <= (r_mag > LIM_POS) ? LIM_POS[VALUE_W-1:0]
                                                            : r_mag[VALUE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE)
        else $error("job taken while busy");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && o_pop && i_job.kind == JOB_QUERY) |=> r_state == S_DIM)
        else $error("query not started");
    a_div_vol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_vol != '0)
        else $error("division by zero volume");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_res.status) |-> r_res.interpolated == '0)
        else $error("error result not zero");
`endif

endmodule

`default_nettype wire

@@ src/multilinear_grid_interpolator.sv @@
// Top level of the multilinear grid interpolator: front end, job queue, back end.
// Depends on mgi_pkg, mgi_front, mgi_fifo, mgi_back.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | request   | i_in_valid / o_in_stall  | i_in_req  (t_in_req)
//   out     | result    | o_out_valid / i_out_stall| o_out_rsp (t_out_rsp)
//   cfg     | write     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// Loads (base point, table value) are written only while the back end is idle; the
// queue takes one request a cycle until it holds four jobs.
// A query scans the base points of each dimension with two or more points, forms
// the cell volume, and builds one product per nonzero corner (zero corners are
// skipped): each corner product is three rounds of four 32x32 limb passes, and the
// divider retires one quotient bit per cycle over 131 bits.
// Reset is synchronous, active low; it clears the queue, the sequencer and the
// point counts (to 1). Memories have no reset and are undefined until loaded.
// A stalled result sits in the output register; the back end waits on it only when
// the next query result is ready, holding back loads too; the front keeps queueing.
`default_nettype none

module multilinear_grid_interpolator (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  mgi_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output mgi_pkg::t_out_rsp o_out_rsp,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  [1:0]        i_cfg_index,
    input  wire  [4:0]        i_cfg_data
);
    import mgi_pkg::*;

    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    // classify requests; no-ops are swallowed here
    mgi_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // decouples request acceptance from the long query sequence
    mgi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    // memories, search, products, divide, saturate
    mgi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_job       (head_job),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire
